// ===== rtl/core/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, codes and controller/datapath interface types for the
// positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int CAPACITY = 64;
   localparam int AW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int DW       = 32;
   localparam int POS_W    = 7;
   localparam int CMPW     = ((CW > POS_W) ? CW : POS_W) + 1;

   // operations
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_AMEND  = 2'd3;

   // response status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_POS   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // store write selection
   localparam logic [2:0] WR_NONE  = 3'd0;
   localparam logic [2:0] WR_UP    = 3'd1;
   localparam logic [2:0] WR_DN    = 3'd2;
   localparam logic [2:0] WR_INS   = 3'd3;
   localparam logic [2:0] WR_AMEND = 3'd4;

   typedef struct packed {
      logic       load;
      logic       init;
      logic       rd_en;
      logic [2:0] wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       res_set;
      logic [1:0] res_code;
      logic       res_hit;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       ins_bad;
      logic       ins_full;
      logic       ins_append;
      logic       del_bad;
      logic       del_last;
      logic       empty;
      logic       rd_last;
      logic       rvld;
      logic       match;
   } stat_type;

endpackage

// ===== rtl/core/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pal_dp.sv =====
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: request registers, entry count, walk index, entry store,
// position checks, match compare and response registers.
// ----------------------------------------------------------------------------
module pal_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  pal_pkg::cmd_type             cmd,
   output pal_pkg::stat_type            stat,
   input  logic [1:0]                   req_operation,
   input  logic [pal_pkg::POS_W-1:0]    req_position,
   input  logic signed [pal_pkg::DW-1:0] req_value,
   input  logic signed [pal_pkg::DW-1:0] req_new_value,
   output logic [1:0]                   rsp_status,
   output logic [pal_pkg::POS_W-1:0]    rsp_found_position,
   output logic [pal_pkg::POS_W-1:0]    rsp_element_count
);

   import pal_pkg::*;

   logic [1:0]       op_ff;
   logic [POS_W-1:0] pos_ff;
   logic [DW-1:0]    val_ff;
   logic [DW-1:0]    nval_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]    ridx_ff, ridx_in;
   logic [AW-1:0]    rtag_ff;
   logic             rvld_ff;
   logic [1:0]       res_status_ff;
   logic [POS_W-1:0] res_found_ff;
   logic [1:0]       rsp_status_ff;
   logic [POS_W-1:0] rsp_found_ff;
   logic [POS_W-1:0] rsp_count_ff;

   logic [CMPW-1:0]  pos_x, cnt_x;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [DW-1:0]    wr_data;
   logic [DW-1:0]    rd_data;

   assign pos_x = CMPW'(pos_ff);
   assign cnt_x = CMPW'(cnt_ff);

   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.ins_bad    = (pos_ff == '0) || (pos_x > cnt_x + CMPW'(1));
      stat.ins_full   = (cnt_ff == CW'(CAPACITY));
      stat.ins_append = (pos_x == cnt_x + CMPW'(1));
      stat.del_bad    = (pos_ff == '0) || (pos_x > cnt_x);
      stat.del_last   = (pos_x == cnt_x);
      stat.empty      = (cnt_ff == '0);
      stat.rvld       = rvld_ff;
      stat.match      = (rd_data == val_ff);
      if (op_ff == OP_INSERT) begin
         stat.rd_last = (ridx_ff == AW'(pos_ff - POS_W'(1)));
      end else begin
         stat.rd_last = (ridx_ff == AW'(cnt_ff - CW'(1)));
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // walk index: down from the top for insert, up otherwise
   always_comb begin
      ridx_in = ridx_ff;
      if (cmd.init) begin
         unique case (op_ff)
            OP_INSERT: ridx_in = AW'(cnt_ff - CW'(1));
            OP_DELETE: ridx_in = AW'(pos_ff);
            default:   ridx_in = '0;
         endcase
      end else if (cmd.rd_en) begin
         ridx_in = (op_ff == OP_INSERT) ? ridx_ff - AW'(1) : ridx_ff + AW'(1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      unique case (cmd.wr_sel)
         WR_UP: begin
            wr_en   = rvld_ff;
            wr_addr = rtag_ff + AW'(1);
         end
         WR_DN: begin
            wr_en   = rvld_ff;
            wr_addr = rtag_ff - AW'(1);
         end
         WR_INS: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff - POS_W'(1));
            wr_data = val_ff;
         end
         WR_AMEND: begin
            wr_en   = 1'b1;
            wr_addr = AW'(res_found_ff - POS_W'(1));
            wr_data = nval_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         rvld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
      if (cmd.load) begin
         op_ff   <= req_operation;
         pos_ff  <= req_position;
         val_ff  <= req_value;
         nval_ff <= req_new_value;
      end
      if (cmd.rd_en) begin
         rtag_ff <= ridx_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         res_found_ff  <= cmd.res_hit ? POS_W'(rtag_ff) + POS_W'(1) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= POS_W'(cnt_ff);
      end
   end

   pal_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ridx_ff),
      .rd_data (rd_data)
   );

   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_element_count  = rsp_count_ff;

endmodule

// ===== rtl/core/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller: sequences checks, shift walks, scans and the response handshake.
// ----------------------------------------------------------------------------
module pal_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pal_pkg::stat_type  stat,
   output pal_pkg::cmd_type   cmd
);

   import pal_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CHECK     = 4'd1;
   localparam logic [3:0] S_UP        = 4'd2;
   localparam logic [3:0] S_UP_TAIL   = 4'd3;
   localparam logic [3:0] S_INS_WR    = 4'd4;
   localparam logic [3:0] S_DN        = 4'd5;
   localparam logic [3:0] S_DN_TAIL   = 4'd6;
   localparam logic [3:0] S_SCAN      = 4'd7;
   localparam logic [3:0] S_SCAN_TAIL = 4'd8;
   localparam logic [3:0] S_AMEND     = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.init = 1'b1;
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.ins_bad) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = ST_BAD_POS;
                     state_in     = S_DONE;
                  end else if (stat.ins_full) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = ST_FULL;
                     state_in     = S_DONE;
                  end else if (stat.ins_append) begin
                     state_in = S_INS_WR;
                  end else begin
                     state_in = S_UP;
                  end
               end
               OP_DELETE: begin
                  if (stat.del_bad) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = ST_BAD_POS;
                     state_in     = S_DONE;
                  end else if (stat.del_last) begin
                     state_in = S_DN_TAIL;
                  end else begin
                     state_in = S_DN;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = ST_NOT_FOUND;
                     state_in     = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_UP: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_sel = WR_UP;
            if (stat.rd_last) begin
               state_in = S_UP_TAIL;
            end
         end
         S_UP_TAIL: begin
            cmd.wr_sel = WR_UP;
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.wr_sel   = WR_INS;
            cmd.cnt_inc  = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            state_in     = S_DONE;
         end
         S_DN: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_sel = WR_DN;
            if (stat.rd_last) begin
               state_in = S_DN_TAIL;
            end
         end
         S_DN_TAIL: begin
            // last moved entry lands here; nothing to move when deleting the tail
            cmd.wr_sel   = WR_DN;
            cmd.cnt_dec  = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            if (stat.rvld && stat.match) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_OK;
               cmd.res_hit  = 1'b1;
               state_in     = (stat.op == OP_AMEND) ? S_AMEND : S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               if (stat.rd_last) begin
                  state_in = S_SCAN_TAIL;
               end
            end
         end
         S_SCAN_TAIL: begin
            cmd.res_set = 1'b1;
            if (stat.rvld && stat.match) begin
               cmd.res_code = ST_OK;
               cmd.res_hit  = 1'b1;
               state_in     = (stat.op == OP_AMEND) ? S_AMEND : S_DONE;
            end else begin
               cmd.res_code = ST_NOT_FOUND;
               state_in     = S_DONE;
            end
         end
         S_AMEND: begin
            cmd.wr_sel = WR_AMEND;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/positional_array_list_core.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed words in a 64-entry store with insert, delete,
// search and amend-first-match operations.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    operation, position, value,
//                                               new_value
//   rsp_      out        rsp_valid/rsp_ready    status, found_position,
//                                               element_count
//
// One request at a time. Insert shifts the entries from the position up,
// then writes the value (an append skips the shift); delete shifts the
// entries above the position down; search and amend scan from the front,
// and amend then writes the new value. The controller returns to idle to
// take the next request. The single-port-read store moves one entry a cycle.
// Reset clears the count and control only; the store is not cleared.
// A new request is taken while the previous response waits; the finished
// result then holds until the response register is free.
// ----------------------------------------------------------------------------
module positional_array_list_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [pal_pkg::POS_W-1:0]     req_position,
   input  logic signed [pal_pkg::DW-1:0] req_value,
   input  logic signed [pal_pkg::DW-1:0] req_new_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [pal_pkg::POS_W-1:0]     rsp_found_position,
   output logic [pal_pkg::POS_W-1:0]     rsp_element_count
);

   import pal_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pal_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_new_value      (req_new_value),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_element_count  (rsp_element_count)
   );

   // a taken request always leaves idle for the check cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= POS_W'(CAPACITY))
      else $error("element count beyond capacity");

   // only a successful search or amend reports a position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_found_position == '0)
      else $error("position reported with failing status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_element_count == POS_W'(CAPACITY))
      else $error("full reported below capacity");

endmodule

// ===== verif/positional_array_list_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_core_tb
// Self-checking bench for the positional array list. A shadow list kept in a
// queue predicts status, match position and count for every request; responses
// are compared in order. Directed corner cases come first, then random
// sequences that swing the list between empty and full under bursty requests
// and an uneven response stall pattern.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [1:0]                status;
   logic [pal_pkg::POS_W-1:0] found_position;
   logic [pal_pkg::POS_W-1:0] element_count;
} list_rsp_type;

class list_tracker;
   logic signed [pal_pkg::DW-1:0] shadow[$];
   list_rsp_type                  pending[$];
   int                            errors;

   function new();
      errors = 0;
   endfunction

   function void note_request(input logic [1:0] op, input logic [pal_pkg::POS_W-1:0] pos,
                              input logic signed [pal_pkg::DW-1:0] val,
                              input logic signed [pal_pkg::DW-1:0] nval);
      int           p;
      int           n;
      int           idx;
      list_rsp_type exp;
      p   = pos;
      n   = shadow.size();
      idx = -1;
      exp.status         = pal_pkg::ST_OK;
      exp.found_position = '0;
      case (op)
         pal_pkg::OP_INSERT: begin
            if (p < 1 || p > n + 1)
               exp.status = pal_pkg::ST_BAD_POS;
            else if (n >= pal_pkg::CAPACITY)
               exp.status = pal_pkg::ST_FULL;
            else
               shadow.insert(p - 1, val);
         end
         pal_pkg::OP_DELETE: begin
            if (p < 1 || p > n)
               exp.status = pal_pkg::ST_BAD_POS;
            else
               shadow.delete(p - 1);
         end
         default: begin
            for (int i = 0; i < n; i++) begin
               if (idx < 0 && shadow[i] == val)
                  idx = i;
            end
            if (idx < 0) begin
               exp.status = pal_pkg::ST_NOT_FOUND;
            end else begin
               exp.found_position = pal_pkg::POS_W'(idx + 1);
               if (op == pal_pkg::OP_AMEND)
                  shadow[idx] = nval;
            end
         end
      endcase
      exp.element_count = pal_pkg::POS_W'(shadow.size());
      pending.push_back(exp);
   endfunction

   function void check_response(input logic [1:0] status,
                                input logic [pal_pkg::POS_W-1:0] found_position,
                                input logic [pal_pkg::POS_W-1:0] element_count);
      list_rsp_type exp;
      if (pending.size() == 0) begin
         $error("response with no request outstanding: status %0d", status);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (status !== exp.status) begin
         $error("status: expected %0d, actual %0d", exp.status, status);
         errors++;
      end
      if (found_position !== exp.found_position) begin
         $error("found_position: expected %0d, actual %0d", exp.found_position,
                found_position);
         errors++;
      end
      if (element_count !== exp.element_count) begin
         $error("element_count: expected %0d, actual %0d", exp.element_count,
                element_count);
         errors++;
      end
   endfunction
endclass

module positional_array_list_core_tb;
   import pal_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = CAPACITY + 16;
   localparam int RANDOM_ITEMS = 1900;

   // request mix of the random part
   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIX    = 2;

   // response stall behaviour
   localparam int RX_OPEN   = 0;
   localparam int RX_CHOPPY = 1;
   localparam int RX_CHOKED = 2;

   logic                    clock;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_operation = OP_INSERT;
   logic [POS_W-1:0]        req_position  = '0;
   logic signed [DW-1:0]    req_value     = '0;
   logic signed [DW-1:0]    req_new_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready     = 1'b0;
   logic [1:0]              rsp_status;
   logic [POS_W-1:0]        rsp_found_position;
   logic [POS_W-1:0]        rsp_element_count;

   list_tracker book;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          rx_mode = RX_OPEN;
   int          rx_left = 0;

   positional_array_list_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_new_value      (req_new_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_element_count  (rsp_element_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hold one request until taken, then keep the burst going or back off
   task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [DW-1:0] val,
                               input logic signed [DW-1:0] nval);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      req_new_value <= nval;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(op, pos, val, nval);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [DW-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: pick_value = $urandom_range(0, 7) - 4;   // small pool, forces duplicates
         1: begin
            case ($urandom_range(0, 3))
               0: pick_value = 32'sh7FFF_FFFF;
               1: pick_value = 32'sh8000_0000;
               2: pick_value = '0;
               default: pick_value = -1;
            endcase
         end
         default: pick_value = $urandom;
      endcase
   endfunction

   // top is the highest legal position; 0 means none is legal
   function automatic logic [POS_W-1:0] pick_position(input int top);
      int r;
      r = $urandom_range(0, 11);
      if (top == 0 || r == 0) begin
         if (top >= 127 || $urandom_range(0, 1) == 0)
            pick_position = '0;
         else
            pick_position = POS_W'($urandom_range(top + 1, 127));
      end else if (r == 1) begin
         pick_position = POS_W'(1);
      end else if (r == 2) begin
         pick_position = POS_W'(top);
      end else begin
         pick_position = POS_W'($urandom_range(1, top));
      end
   endfunction

   task automatic run_directed();
      send_request(OP_DELETE, 1,   0, 0);              // empty list
      send_request(OP_SEARCH, 0,   0, 0);
      send_request(OP_AMEND,  0,   0, 1);
      send_request(OP_INSERT, 0,   5, 0);              // position zero
      send_request(OP_INSERT, 2,   5, 0);              // beyond count+1
      send_request(OP_INSERT, 127, 5, 0);
      send_request(OP_INSERT, 1,   32'sh7FFF_FFFF, 0);
      send_request(OP_INSERT, 1,   32'sh8000_0000, 0); // at the front
      send_request(OP_INSERT, 3,   0, 0);              // append
      send_request(OP_INSERT, 2,   -1, 0);             // middle
      send_request(OP_INSERT, 5,   32'sh7FFF_FFFF, 0); // duplicate
      send_request(OP_SEARCH, 64,  32'sh7FFF_FFFF, 0); // first of two
      send_request(OP_SEARCH, 127, 32'sh8000_0000, 0);
      send_request(OP_SEARCH, 0,   12345, 0);
      send_request(OP_AMEND,  0,   32'sh7FFF_FFFF, -2);
      send_request(OP_SEARCH, 0,   32'sh7FFF_FFFF, 0); // now the later copy
      send_request(OP_AMEND,  0,   777, 32'sh7FFF_FFFF);
      send_request(OP_DELETE, 0,   0, 0);
      send_request(OP_DELETE, 6,   0, 0);              // count+1
      send_request(OP_DELETE, 127, 0, 0);
      send_request(OP_DELETE, 5,   0, 0);              // last
      send_request(OP_DELETE, 1,   0, 0);              // first
      send_request(OP_SEARCH, 0,   0, 0);
      send_request(OP_DELETE, 2,   0, 0);
   endtask

   task automatic run_random(input int items);
      int                   k;
      int                   mode;
      int                   seg_left;
      int                   n;
      int                   r;
      logic [1:0]           op;
      logic [POS_W-1:0]     pos;
      logic signed [DW-1:0] val;
      logic signed [DW-1:0] nval;
      mode     = MODE_GROW;            // fill to capacity early on
      seg_left = 120;
      for (k = 0; k < items; k++) begin
         if (seg_left == 0) begin
            mode     = $urandom_range(MODE_GROW, MODE_MIX);
            seg_left = $urandom_range(20, 150);
         end
         seg_left--;
         n = book.shadow.size();
         r = $urandom_range(0, 99);
         case (mode)
            MODE_GROW:   op = (r < 65) ? OP_INSERT : (r < 75) ? OP_DELETE :
                              (r < 88) ? OP_SEARCH : OP_AMEND;
            MODE_SHRINK: op = (r < 15) ? OP_INSERT : (r < 70) ? OP_DELETE :
                              (r < 85) ? OP_SEARCH : OP_AMEND;
            default:     op = (r < 35) ? OP_INSERT : (r < 60) ? OP_DELETE :
                              (r < 80) ? OP_SEARCH : OP_AMEND;
         endcase
         if (op == OP_INSERT)
            pos = pick_position(n + 1);
         else if (op == OP_DELETE)
            pos = pick_position(n);
         else
            pos = POS_W'($urandom_range(0, 127));
         if ((op == OP_SEARCH || op == OP_AMEND) && n > 0 && $urandom_range(0, 9) < 7)
            val = book.shadow[$urandom_range(0, n - 1)];
         else
            val = pick_value();
         nval = pick_value();
         send_request(op, pos, val, nval);
      end
   endtask

   // receiver: switches between open, choppy and nearly blocked spells
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_mode   <= RX_OPEN;
         rx_left   <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            book.check_response(rsp_status, rsp_found_position, rsp_element_count);
         if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_OPEN, RX_CHOKED);
            rx_left <= $urandom_range(16, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("positional_array_list_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("positional_array_list_core test passed");
      end else begin
         $display("positional_array_list_core test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pal_pkg.sv
rtl/core/pal_ram.sv
rtl/core/pal_dp.sv
rtl/core/pal_ctrl.sv
rtl/core/positional_array_list_core.sv
verif/positional_array_list_core_tb.sv
